// ----- design/nccd_pkg.sv -----
// package for the multiplexed display controller
// shared types, codes, reset values and the transaction payload structs
// no dependencies
package nccd_pkg;

    // default number of multiplexed digits
    localparam int DIGITS_DEF = 8;

    // field and register widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int LAYOUT_N   = 8;

    // digit codes and limits
    localparam logic [3:0] BLANK_CODE = 4'hF;
    localparam logic [3:0] ON_FULL    = 4'd8;
    localparam logic [3:0] BRIGHT_MIN = 4'd1;
    localparam logic [3:0] BRIGHT_MAX = 4'd9;
    localparam logic [4:0] HOUR_SAT   = 5'd31;

    // configuration reset values
    localparam logic [15:0] RST_DATE_INTERVAL = 16'd30;
    localparam logic [15:0] RST_DATE_SPAN     = 16'd3;
    localparam logic [15:0] RST_USER_HOLD     = 16'd300;
    localparam logic [1:0]  RST_FORMAT_MODE   = 2'd3;
    localparam logic [3:0]  RST_BRIGHT_DAY    = 4'd6;
    localparam logic [3:0]  RST_BRIGHT_NIGHT  = 4'd3;
    localparam logic [4:0]  RST_HOUR_DAY      = 5'd7;
    localparam logic [4:0]  RST_HOUR_NIGHT    = 5'd23;

    // operation codes of an input transaction
    typedef enum logic [1:0] {
        OP_SCAN   = 2'd0,
        OP_SECOND = 2'd1,
        OP_LOAD   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DATE_INTERVAL = 3'd0,
        CFG_DATE_SPAN     = 3'd1,
        CFG_USER_HOLD     = 3'd2,
        CFG_FORMAT_MODE   = 3'd3,
        CFG_BRIGHT_DAY    = 3'd4,
        CFG_BRIGHT_NIGHT  = 3'd5,
        CFG_HOUR_DAY      = 3'd6,
        CFG_HOUR_NIGHT    = 3'd7
    } t_cfg_idx;

    // input transaction payload
    typedef struct packed {
        t_op         opcode;
        logic [5:0]  hour_bcd;
        logic [4:0]  hour12_bcd;
        logic [6:0]  minute_bcd;
        logic [6:0]  second_bcd;
        logic [7:0]  year_bcd;
        logic [4:0]  month_bcd;
        logic [5:0]  day_bcd;
        logic [31:0] user_digits;
        logic [7:0]  user_commas;
    } t_in_item;

    // output transaction payload
    typedef struct packed {
        logic [3:0] digit_code;
        logic       comma_on;
        logic [7:0] anode_select;
        logic [3:0] on_units;
        logic       night_active;
    } t_out_item;

    // configuration register file contents
    typedef struct packed {
        logic [15:0] date_interval;
        logic [15:0] date_span;
        logic [15:0] user_hold;
        logic [1:0]  format_mode;
        logic [3:0]  bright_day;
        logic [3:0]  bright_night;
        logic [4:0]  hour_day;
        logic [4:0]  hour_night;
    } t_cfg;

    // per-operation strobes from the input stage
    typedef struct packed {
        logic scan;
        logic second;
        logic load;
        logic clear;
    } t_ctl;

endpackage

// ----- design/nccd_cfg_regs.sv -----
// configuration register file of the display controller
// plain indexed write port, no read-back
// depends on nccd_pkg
module nccd_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [nccd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [nccd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output nccd_pkg::t_cfg                 o_cfg
);
    import nccd_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DATE_INTERVAL: n_cfg.date_interval = i_cfg_data;
                CFG_DATE_SPAN:     n_cfg.date_span     = i_cfg_data;
                CFG_USER_HOLD:     n_cfg.user_hold     = i_cfg_data;
                CFG_FORMAT_MODE:   n_cfg.format_mode   = i_cfg_data[1:0];
                CFG_BRIGHT_DAY:    n_cfg.bright_day    = i_cfg_data[3:0];
                CFG_BRIGHT_NIGHT:  n_cfg.bright_night  = i_cfg_data[3:0];
                CFG_HOUR_DAY:      n_cfg.hour_day      = i_cfg_data[4:0];
                CFG_HOUR_NIGHT:    n_cfg.hour_night    = i_cfg_data[4:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.date_interval <= RST_DATE_INTERVAL;
            r_cfg.date_span     <= RST_DATE_SPAN;
            r_cfg.user_hold     <= RST_USER_HOLD;
            r_cfg.format_mode   <= RST_FORMAT_MODE;
            r_cfg.bright_day    <= RST_BRIGHT_DAY;
            r_cfg.bright_night  <= RST_BRIGHT_NIGHT;
            r_cfg.hour_day      <= RST_HOUR_DAY;
            r_cfg.hour_night    <= RST_HOUR_NIGHT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- design/nccd_compose.sv -----
// digit and comma store with the time / date composer and hold counters
// updated on second ticks, user loads and hold clears
// depends on nccd_pkg
module nccd_compose #(
    parameter int DIGITS = nccd_pkg::DIGITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  nccd_pkg::t_cfg         i_cfg,
    input  nccd_pkg::t_ctl         i_ctl,
    input  nccd_pkg::t_in_item     i_item,
    output logic [DIGITS-1:0][3:0] o_digits,
    output logic [DIGITS-1:0]      o_commas,
    output logic [4:0]             o_hour
);
    import nccd_pkg::*;

    logic [DIGITS-1:0][3:0] r_digits;
    logic [DIGITS-1:0][3:0] n_digits;
    logic [DIGITS-1:0]      r_commas;
    logic [DIGITS-1:0]      n_commas;
    logic [15:0]            r_date_cnt;
    logic [15:0]            n_date_cnt;
    logic [15:0]            r_user_cnt;
    logic [15:0]            n_user_cnt;
    logic [4:0]             r_hour;
    logic [4:0]             n_hour;

    logic [LAYOUT_N-1:0][3:0] lay_digits;
    logic [LAYOUT_N-1:0]      lay_commas;
    logic [3:0]               hour_hi;
    logic [3:0]               hour_lo;
    logic [5:0]               hour_bin;
    logic                     show_time;
    logic [16:0]              date_end;
    logic                     date_wrap;
    logic                     clock_mode;

    // hour digits in the selected 12 / 24-hour form
    always_comb begin
        if (i_cfg.format_mode[1]) begin
            hour_hi = {2'b00, i_item.hour_bcd[5:4]};
            hour_lo = i_item.hour_bcd[3:0];
        end else begin
            hour_hi = {3'b000, i_item.hour12_bcd[4]};
            hour_lo = i_item.hour12_bcd[3:0];
        end
    end

    // binary hour, tens times ten via shifts, saturated for the hour latch
    assign hour_bin = {1'b0, i_item.hour_bcd[5:4], 3'b000}
                    + {3'b000, i_item.hour_bcd[5:4], 1'b0}
                    + {2'b00, i_item.hour_bcd[3:0]};

    // date window bookkeeping, end of window summed without wrap
    assign clock_mode = (r_user_cnt == 16'd0);
    assign show_time  = (r_date_cnt <= i_cfg.date_interval);
    assign date_end   = {1'b0, i_cfg.date_interval} + {1'b0, i_cfg.date_span};
    assign date_wrap  = ({1'b0, r_date_cnt} >= date_end);

    // eight-position layout of time or date
    always_comb begin
        lay_commas = '0;
        if (!show_time) begin
            lay_digits = {i_item.day_bcd[3:0], {2'b00, i_item.day_bcd[5:4]},
                          i_item.month_bcd[3:0], {3'b000, i_item.month_bcd[4]},
                          i_item.year_bcd[3:0], i_item.year_bcd[7:4],
                          4'd0, 4'd2};
        end else if (i_cfg.format_mode[0]) begin
            lay_digits = {i_item.second_bcd[3:0], {1'b0, i_item.second_bcd[6:4]},
                          BLANK_CODE,
                          i_item.minute_bcd[3:0], {1'b0, i_item.minute_bcd[6:4]},
                          BLANK_CODE, hour_lo, hour_hi};
            lay_commas[2] = 1'b1;
            lay_commas[5] = 1'b1;
        end else begin
            lay_digits = {BLANK_CODE,
                          i_item.second_bcd[3:0], {1'b0, i_item.second_bcd[6:4]},
                          i_item.minute_bcd[3:0], {1'b0, i_item.minute_bcd[6:4]},
                          hour_lo, hour_hi, BLANK_CODE};
        end
    end

    // next state of store, counters and hour latch
    always_comb begin
        n_digits   = r_digits;
        n_commas   = r_commas;
        n_date_cnt = r_date_cnt;
        n_user_cnt = r_user_cnt;
        n_hour     = r_hour;
        if (i_ctl.second) begin
            if (clock_mode) begin
                n_hour = (hour_bin > 6'(HOUR_SAT)) ? HOUR_SAT : hour_bin[4:0];
                for (int i = 0; i < DIGITS; i++) begin
                    if (i < LAYOUT_N) begin
                        n_digits[i] = lay_digits[3'(i)];
                        n_commas[i] = lay_commas[3'(i)];
                    end else begin
                        n_digits[i] = BLANK_CODE;
                        n_commas[i] = 1'b0;
                    end
                end
                n_date_cnt = (!show_time && date_wrap) ? 16'd1 : r_date_cnt + 16'd1;
            end else begin
                n_user_cnt = r_user_cnt - 16'd1;
            end
        end else if (i_ctl.load) begin
            for (int i = 0; i < DIGITS; i++) begin
                if (i < LAYOUT_N) begin
                    n_digits[i] = i_item.user_digits[4*i +: 4];
                    n_commas[i] = i_item.user_commas[i];
                end
            end
            n_user_cnt = i_cfg.user_hold;
        end else if (i_ctl.clear) begin
            n_user_cnt = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digits   <= {DIGITS{BLANK_CODE}};
            r_commas   <= '0;
            r_date_cnt <= 16'd0;
            r_user_cnt <= 16'd0;
            r_hour     <= 5'd0;
        end else begin
            r_digits   <= n_digits;
            r_commas   <= n_commas;
            r_date_cnt <= n_date_cnt;
            r_user_cnt <= n_user_cnt;
            r_hour     <= n_hour;
        end
    end

    assign o_digits = r_digits;
    assign o_commas = r_commas;
    assign o_hour   = r_hour;

endmodule

// ----- design/nccd_scan.sv -----
// scan position, day / night brightness and the result register
// one result transaction per scan tick, held until taken
// depends on nccd_pkg
module nccd_scan #(
    parameter int DIGITS = nccd_pkg::DIGITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  nccd_pkg::t_cfg         i_cfg,
    input  nccd_pkg::t_ctl         i_ctl,
    input  logic [DIGITS-1:0][3:0] i_digits,
    input  logic [DIGITS-1:0]      i_commas,
    input  logic [4:0]             i_hour,
    input  logic                   i_out_stall,
    output logic                   o_out_free,
    output logic                   o_out_valid,
    output nccd_pkg::t_out_item    o_out_data
);
    import nccd_pkg::*;

    localparam int POS_W = $clog2(DIGITS);

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic             r_out_valid;
    logic             n_out_valid;
    t_out_item        r_out;
    t_out_item        n_out;

    logic             night;
    logic [3:0]       bright;
    logic [7:0]       anode;

    // night window, wraps past midnight when night starts after day
    always_comb begin
        if (i_cfg.hour_night > i_cfg.hour_day) begin
            night = (i_hour < i_cfg.hour_day) || (i_hour >= i_cfg.hour_night);
        end else begin
            night = (i_hour >= i_cfg.hour_night) && (i_hour < i_cfg.hour_day);
        end
        bright = night ? i_cfg.bright_night : i_cfg.bright_day;
    end

    // one-hot anode for the first eight positions
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            anode[k] = (32'(r_pos) == k);
        end
    end

    // result of the current position
    always_comb begin
        n_out.digit_code   = i_digits[r_pos];
        n_out.comma_on     = i_commas[r_pos];
        n_out.anode_select = anode;
        n_out.on_units     = (bright >= BRIGHT_MIN && bright <= BRIGHT_MAX)
                           ? bright - 4'd1 : ON_FULL;
        n_out.night_active = night;
    end

    // scan advance and result register handshake
    assign o_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_pos       = r_pos;
        n_out_valid = r_out_valid && i_out_stall;
        if (i_ctl.scan) begin
            n_pos       = (r_pos == POS_W'(DIGITS - 1)) ? '0 : r_pos + 1'b1;
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    // payload register, loaded only with a new result
    always_ff @(posedge i_clk) begin
        if (i_ctl.scan) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- design/nixie_clock_display_controller_top.sv -----
// Multiplexed eight-digit display controller, top level.
// A scan tick's result goes from the input register into the result register when it frees.
// Throughput: one transaction per cycle while no scan tick waits for the result register.
// Second ticks, loads and clears update the composer from the input register and give no result.
// Reset (synchronous, active low) blanks all digits, clears commas, counters and scan position,
// and restores the configuration defaults.
module nixie_clock_display_controller_top #(
    parameter int DIGITS = nccd_pkg::DIGITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [nccd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [nccd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  nccd_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output nccd_pkg::t_out_item             o_out_data
);
    import nccd_pkg::*;

    logic                   r_in_valid;
    logic                   n_in_valid;
    t_in_item               r_in;
    t_cfg                   cfg;
    t_ctl                   ctl;
    logic                   out_free;
    logic                   step_go;
    logic                   in_take;
    logic [DIGITS-1:0][3:0] digits;
    logic [DIGITS-1:0]      commas;
    logic [4:0]             hour;

    // configuration registers
    nccd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // input stage: a scan tick waits only for room in the result register
    assign step_go    = r_in_valid && ((r_in.opcode != OP_SCAN) || out_free);
    assign o_in_stall = r_in_valid && !step_go;
    assign in_take    = i_in_valid && !o_in_stall;
    assign n_in_valid = in_take || (r_in_valid && !step_go);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    // operation decode of the held transaction
    always_comb begin
        ctl = '0;
        if (step_go) begin
            unique case (r_in.opcode)
                OP_SCAN:   ctl.scan   = 1'b1;
                OP_SECOND: ctl.second = 1'b1;
                OP_LOAD:   ctl.load   = 1'b1;
                OP_CLEAR:  ctl.clear  = 1'b1;
                default:   ctl = '0;
            endcase
        end
    end

    // digit store and composer
    nccd_compose #(
        .DIGITS (DIGITS)
    ) u_compose (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_ctl    (ctl),
        .i_item   (r_in),
        .o_digits (digits),
        .o_commas (commas),
        .o_hour   (hour)
    );

    // scan and result register
    nccd_scan #(
        .DIGITS (DIGITS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_ctl       (ctl),
        .i_digits    (digits),
        .i_commas    (commas),
        .i_hour      (hour),
        .i_out_stall (i_out_stall),
        .o_out_free  (out_free),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
